### rtl/core/g711_pkg.sv
// ----------------------------------------------------------------------------
// g711_pkg
// shared types and constants for the g.711 mu-law / a-law codec
// ----------------------------------------------------------------------------
`default_nettype none

package g711_pkg;

  typedef enum logic {
    LAW_MU = 1'b0,
    LAW_A  = 1'b1
  } law_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef struct packed {
    law_t law;
    dir_t dir;
  } cfg_t;

  // register index, taken from paddr bit 2
  localparam logic REG_LAW = 1'b0;
  localparam logic REG_DIR = 1'b1;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [15:0] MU_BIAS    = 16'h0084;
  localparam logic [7:0]  MU_MASK_P  = 8'hFF;
  localparam logic [7:0]  MU_MASK_N  = 8'h7F;
  localparam logic [7:0]  A_MASK_P   = 8'hD5;
  localparam logic [7:0]  A_MASK_N   = 8'h55;
  localparam logic [7:0]  CLIP_CODE  = 8'h7F;
  localparam logic [15:0] A_SEG0_OFS = 16'h0008;
  localparam logic [15:0] A_SEG1_OFS = 16'h0108;

endpackage

`default_nettype wire

### rtl/core/g711_stream_if.sv
// ----------------------------------------------------------------------------
// g711 stream interfaces
// valid/ready channels for linear samples or code bytes, in and out
// ----------------------------------------------------------------------------
`default_nettype none

interface g711_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] data_in;
  logic               last_in;

  modport source (output valid, output data_in, output last_in, input ready);
  modport sink   (input valid, input data_in, input last_in, output ready);
endinterface

interface g711_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] data_out;
  logic               last_out;

  modport source (output valid, output data_out, output last_out, input ready);
  modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

`default_nettype wire

### rtl/core/g711_cfg_regs.sv
// ----------------------------------------------------------------------------
// g711_cfg_regs
// apb register file holding the law and direction selects
// ----------------------------------------------------------------------------
`default_nettype none

module g711_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [g711_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [g711_pkg::CFG_DW-1:0]    pwdata,
  output logic      [g711_pkg::CFG_DW-1:0]    prdata,
  output logic                                pready,
  output g711_pkg::cfg_t                      cfg
);

  g711_pkg::cfg_t cfg_r;
  g711_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        g711_pkg::REG_LAW: cfg_nxt.law = g711_pkg::law_t'(pwdata[0]);
        g711_pkg::REG_DIR: cfg_nxt.dir = g711_pkg::dir_t'(pwdata[0]);
        default:           cfg_nxt     = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{law: g711_pkg::LAW_MU, dir: g711_pkg::DIR_ENCODE};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      g711_pkg::REG_LAW: prdata[0] = cfg_r.law;
      g711_pkg::REG_DIR: prdata[0] = cfg_r.dir;
      default:           prdata    = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/core/g711_encoder.sv
// ----------------------------------------------------------------------------
// g711_encoder
// linear 16-bit sample to 8-bit mu-law or a-law code, combinational
// ----------------------------------------------------------------------------
`default_nettype none

module g711_encoder (
  input  wire g711_pkg::law_t   law,
  input  wire logic signed [15:0] sample,
  output logic [7:0]            code
);

  // number of segment ends (0xff, 0x1ff .. 0x7fff) the magnitude exceeds
  function automatic logic [3:0] find_segment(input logic [16:0] mag);
    logic [3:0] seg;
    seg = 4'd0;
    for (int i = 8; i <= 16; i++) begin
      if (mag[i]) seg = 4'(i - 7);
    end
    return seg;
  endfunction

  logic signed [17:0] s_ext;
  logic signed [17:0] mag_s;
  logic [16:0]        mag;
  logic [7:0]         mask;
  logic [3:0]         seg;
  logic [3:0]         shamt;
  logic [16:0]        shifted;

  assign s_ext = 18'(sample);

  always_comb begin
    if (law == g711_pkg::LAW_MU) begin
      if (sample < 0) begin
        mag_s = 18'sd132 - s_ext;
        mask  = g711_pkg::MU_MASK_N;
      end else begin
        mag_s = s_ext + 18'sd132;
        mask  = g711_pkg::MU_MASK_P;
      end
    end else begin
      if (sample < 0) begin
        mag_s = -s_ext - 18'sd8;
        mask  = g711_pkg::A_MASK_N;
      end else begin
        mag_s = s_ext;
        mask  = g711_pkg::A_MASK_P;
      end
    end
  end

  // a-law floors small negative samples at zero
  assign mag = (mag_s < 0) ? 17'd0 : mag_s[16:0];
  assign seg = find_segment(mag);

  // a-law segment zero keeps the same step as segment one
  assign shamt   = (law == g711_pkg::LAW_A && seg == 4'd0) ? 4'd4 : seg + 4'd3;
  assign shifted = mag >> shamt;

  always_comb begin
    if (seg[3]) begin
      code = g711_pkg::CLIP_CODE ^ mask;
    end else begin
      code = {1'b0, seg[2:0], shifted[3:0]} ^ mask;
    end
  end

endmodule

`default_nettype wire

### rtl/core/g711_decoder.sv
// ----------------------------------------------------------------------------
// g711_decoder
// 8-bit mu-law or a-law code to linear 16-bit sample, combinational
// ----------------------------------------------------------------------------
`default_nettype none

module g711_decoder (
  input  wire g711_pkg::law_t law,
  input  wire logic [7:0]   code,
  output logic signed [15:0] sample
);

  logic [7:0]  u;
  logic [8:0]  mu_base;
  logic [15:0] mu_t;
  logic [15:0] mu_val;
  logic [7:0]  a;
  logic [2:0]  a_seg;
  logic [15:0] a_m;
  logic [15:0] a_t;
  logic [15:0] a_val;

  assign u       = ~code;
  assign mu_base = 9'({u[3:0], 3'b000}) + 9'(g711_pkg::MU_BIAS);
  assign mu_t    = 16'(mu_base) << u[6:4];
  assign mu_val  = u[7] ? (g711_pkg::MU_BIAS - mu_t) : (mu_t - g711_pkg::MU_BIAS);

  assign a     = code ^ g711_pkg::A_MASK_N;
  assign a_seg = a[6:4];
  assign a_m   = 16'({a[3:0], 4'b0000});

  always_comb begin
    if (a_seg == 3'd0) begin
      a_t = a_m + g711_pkg::A_SEG0_OFS;
    end else if (a_seg == 3'd1) begin
      a_t = a_m + g711_pkg::A_SEG1_OFS;
    end else begin
      a_t = (a_m + g711_pkg::A_SEG1_OFS) << (a_seg - 3'd1);
    end
  end

  assign a_val  = a[7] ? a_t : (16'd0 - a_t);
  assign sample = signed'((law == g711_pkg::LAW_MU) ? mu_val : a_val);

endmodule

`default_nettype wire

### rtl/core/g711_pcm_codec.sv
// ----------------------------------------------------------------------------
// g711_pcm_codec
// g.711 mu-law / a-law encoder and decoder with apb law and direction selects
// ----------------------------------------------------------------------------
// channel   role     payload
// in_chan   sink     data_in (s16: sample, or code in bits 7..0), last_in
// out_chan  source   data_out (s16: code 0..255, or sample), last_out
// cfg_*     apb      reg 0 @0x0 law_select, reg 1 @0x4 direction
//
// one request per cycle sustained while results are taken; path: input register,
// codec logic, result register
// rst_n clears the valid flags and both selects (mu-law, encode)
// a stalled result holds in the output register while the input register
// still takes a request, so the input side stops only when both are full
// ----------------------------------------------------------------------------
`default_nettype none

module g711_pcm_codec (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  g711_in_if.sink                            in_chan,
  g711_out_if.source                         out_chan,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [g711_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [g711_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [g711_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  g711_pkg::cfg_t     cfg;

  logic               in_valid_r, in_valid_nxt;
  logic signed [15:0] in_data_r,  in_data_nxt;
  logic               in_last_r,  in_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_data_r,  out_data_nxt;
  logic               out_last_r,  out_last_nxt;

  logic               advance;
  logic               take_in;
  logic [7:0]         enc_code;
  logic signed [15:0] dec_sample;
  logic signed [15:0] result;

  g711_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  g711_encoder u_enc (
    .law    (cfg.law),
    .sample (in_data_r),
    .code   (enc_code)
  );

  g711_decoder u_dec (
    .law    (cfg.law),
    .code   (in_data_r[7:0]),
    .sample (dec_sample)
  );

  assign result = (cfg.dir == g711_pkg::DIR_DECODE) ? dec_sample
                                                    : signed'({8'h00, enc_code});

  // result register frees when empty or taken this cycle
  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !in_valid_r || advance;
  assign take_in       = in_chan.valid && in_chan.ready;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_data_nxt   = in_data_r;
    in_last_nxt   = in_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = in_valid_r;
      out_data_nxt  = result;
      out_last_nxt  = in_last_r;
      in_valid_nxt  = 1'b0;
    end
    if (take_in) begin
      in_valid_nxt = 1'b1;
      in_data_nxt  = in_chan.data_in;
      in_last_nxt  = in_chan.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    in_last_r  <= in_last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.data_out = out_data_r;
  assign out_chan.last_out = out_last_r;

endmodule

`default_nettype wire

### tb/sv/g711_pcm_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g711_pcm_codec_tb
// self-checking bench for the mu-law / a-law codec: law and direction are set
// over apb between phases, requests are sent with random gaps and output
// stalls, and every result is compared with a local companding predictor
// ----------------------------------------------------------------------------

module g711_pcm_codec_tb;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 130;

  typedef struct {
    logic [15:0] data;
    logic        last;
  } codec_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [g711_pkg::CFG_AW-1:0] cfg_paddr;
  logic [g711_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [g711_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  g711_in_if  in_chan ();
  g711_out_if out_chan ();

  g711_pcm_codec dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  g711_pkg::law_t cur_law;
  g711_pkg::dir_t cur_dir;
  codec_result_t  awaited_results[$];
  int             mismatches;
  int             quiet_cycles;
  bit             src_idle;
  bit             sink_idle;
  logic           hold_toggle;
  logic           hold_seen;
  int             hold_cnt;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int segment_of(input int mag);
    int seg;
    seg = 0;
    while (seg < 8 && mag > ((256 << seg) - 1))
      seg++;
    return seg;
  endfunction

  // companding predictor: code byte on encode, linear sample on decode
  function automatic logic [15:0] g711_transform(input g711_pkg::law_t law,
                                                 input g711_pkg::dir_t dir,
                                                 input logic [15:0] raw);
    int         s;
    int         mag;
    int         seg;
    int         t;
    logic [7:0] mask;
    logic [7:0] code;
    logic [7:0] u;
    s = int'($signed(raw));
    if (dir == g711_pkg::DIR_ENCODE) begin
      if (law == g711_pkg::LAW_MU) begin
        mag  = (s < 0) ? int'(g711_pkg::MU_BIAS) - s : s + int'(g711_pkg::MU_BIAS);
        mask = (s < 0) ? g711_pkg::MU_MASK_N : g711_pkg::MU_MASK_P;
      end else begin
        mag  = (s >= 0) ? s : -s - 8;
        if (mag < 0)
          mag = 0;
        mask = (s >= 0) ? g711_pkg::A_MASK_P : g711_pkg::A_MASK_N;
      end
      seg = segment_of(mag);
      if (seg >= 8)
        code = g711_pkg::CLIP_CODE ^ mask;
      else if (law == g711_pkg::LAW_A && seg < 2)
        code = 8'((seg << 4) | ((mag >> 4) & 15)) ^ mask;
      else
        code = 8'((seg << 4) | ((mag >> (seg + 3)) & 15)) ^ mask;
      return {8'h00, code};
    end
    if (law == g711_pkg::LAW_MU) begin
      u = ~raw[7:0];
      t = ((int'(u[3:0]) * 8) + int'(g711_pkg::MU_BIAS)) << u[6:4];
      return u[7] ? 16'(int'(g711_pkg::MU_BIAS) - t) : 16'(t - int'(g711_pkg::MU_BIAS));
    end
    u = raw[7:0] ^ g711_pkg::A_MASK_N;
    t = int'(u[3:0]) * 16;
    if (u[6:4] == 3'd0)
      t = t + int'(g711_pkg::A_SEG0_OFS);
    else if (u[6:4] == 3'd1)
      t = t + int'(g711_pkg::A_SEG1_OFS);
    else
      t = (t + int'(g711_pkg::A_SEG1_OFS)) << (u[6:4] - 1);
    return u[7] ? 16'(t) : 16'(-t);
  endfunction

  // encode samples lean on segment edges and small magnitudes
  function automatic logic [15:0] rand_sample(input g711_pkg::dir_t dir);
    int r;
    int mag;
    if (dir == g711_pkg::DIR_DECODE)
      return 16'($urandom);
    r = $urandom_range(9);
    if (r < 4)
      return 16'($urandom);
    if (r < 7)
      mag = (1 << $urandom_range(8, 15)) - int'($urandom_range(0, 140));
    else
      mag = $urandom_range(0, 300);
    if ($urandom_range(1))
      mag = -mag - int'($urandom_range(1));
    return 16'(mag);
  endfunction

  // scoreboard and watchdog
  always @(posedge clk) begin
    codec_result_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        awaited_results.push_back('{g711_transform(cur_law, cur_dir, in_chan.data_in),
                                    in_chan.last_in});
      if (out_chan.valid && out_chan.ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result data_out %h last_out %b", $time,
                   out_chan.data_out, out_chan.last_out);
        end else begin
          want = awaited_results.pop_front();
          if (out_chan.data_out !== want.data) begin
            mismatches++;
            $display("%0t: data_out mismatch, expected %h, got %h", $time,
                     want.data, out_chan.data_out);
          end
          if (out_chan.last_out !== want.last) begin
            mismatches++;
            $display("%0t: last_out mismatch, expected %b, got %b", $time,
                     want.last, out_chan.last_out);
          end
        end
      end
    end
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      out_chan.ready <= 1'b0;
      hold_cnt       <= hold_cnt - 1;
    end else if (hold_seen != hold_toggle) begin
      hold_seen      <= hold_toggle;
      hold_cnt       <= HOLD_CYCLES - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !(sink_idle && $urandom_range(99) < 26);
    end
  end

  // entered and left at a falling edge
  task automatic send_request(input logic [15:0] data, input logic last);
    while (src_idle && $urandom_range(99) < 26) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.data_in <= data;
    in_chan.last_in <= last;
    do
      @(posedge clk);
    while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do
      @(posedge clk);
    while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == g711_pkg::REG_LAW)
      cur_law = g711_pkg::law_t'(value[0]);
    else
      cur_dir = g711_pkg::dir_t'(value[0]);
    @(negedge clk);
  endtask

  // selects left at their reset values: mu-law encode
  task automatic test_reset_selects();
    send_request(16'sd0, 1'b0);
    send_request(16'sd1000, 1'b1);
    send_request(-16'sd1000, 1'b0);
    wait_all_results();
  endtask

  // extremes and the clip boundary; upper register bits must be dropped
  task automatic test_mu_encode();
    write_reg(g711_pkg::REG_DIR, 32'hFFFF_FFFE);
    write_reg(g711_pkg::REG_LAW, 32'h0000_0000);
    send_request(16'sd0, 1'b0);
    send_request(-16'sd1, 1'b1);
    send_request(16'sd32767, 1'b0);
    send_request(16'h8000, 1'b1);
    send_request(16'sd32635, 1'b0);
    send_request(16'sd32636, 1'b1);
    send_request(-16'sd32636, 1'b0);
    wait_all_results();
  endtask

  task automatic test_a_encode();
    write_reg(g711_pkg::REG_LAW, 32'h0000_0001);
    send_request(16'sd0, 1'b1);
    send_request(-16'sd8, 1'b0);
    send_request(-16'sd9, 1'b1);
    send_request(16'sd32767, 1'b0);
    send_request(16'h8000, 1'b1);
    send_request(16'sd16, 1'b0);
    wait_all_results();
  endtask

  // code byte only in bits 7..0, upper byte must be ignored
  task automatic test_decode();
    write_reg(g711_pkg::REG_DIR, 32'hFFFF_FFFF);
    send_request(16'h0000, 1'b0);
    send_request(16'h00FF, 1'b1);
    send_request(16'h00D5, 1'b0);
    send_request(16'hFF2A, 1'b1);
    wait_all_results();
    write_reg(g711_pkg::REG_LAW, 32'hFFFF_FFFE);
    send_request(16'h0000, 1'b1);
    send_request(16'h00FF, 1'b0);
    send_request(16'h007F, 1'b1);
    send_request(16'hA580, 1'b0);
    wait_all_results();
  endtask

  // all four law and direction pairs first, then random settings
  task automatic test_random_phases();
    logic [31:0] law_word;
    logic [31:0] dir_word;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    for (int p = 0; p < 8; p++) begin
      law_word = $urandom;
      dir_word = $urandom;
      if (p < 4) begin
        law_word[0] = p[0];
        dir_word[0] = p[1];
      end
      write_reg(g711_pkg::REG_LAW, law_word);
      write_reg(g711_pkg::REG_DIR, dir_word);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(rand_sample(cur_dir), $urandom_range(7) == 0);
      wait_all_results();
    end
  endtask

  task automatic test_back_to_back();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    for (int n = 0; n < 120; n++)
      send_request(rand_sample(cur_dir), $urandom_range(7) == 0);
    wait_all_results();
  endtask

  // output held off while requests keep coming, so the input side stalls
  task automatic test_output_hold_off();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    @(posedge clk);
    hold_toggle = ~hold_toggle;
    @(negedge clk);
    for (int n = 0; n < 60; n++)
      send_request(rand_sample(cur_dir), $urandom_range(7) == 0);
    wait_all_results();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.data_in = '0;
    in_chan.last_in = 1'b0;
    out_chan.ready  = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    cur_law         = g711_pkg::LAW_MU;
    cur_dir         = g711_pkg::DIR_ENCODE;
    mismatches      = 0;
    quiet_cycles    = 0;
    src_idle        = 1'b1;
    sink_idle       = 1'b1;
    hold_toggle     = 1'b0;
    hold_seen       = 1'b0;
    hold_cnt        = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_selects();
    test_mu_encode();
    test_a_encode();
    test_decode();
    test_random_phases();
    test_back_to_back();
    test_output_hold_off();

    wait_all_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
